/* hw/rtl/lse_pkg.sv */
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants of the LIFO stack engine: the transfer
// payloads, the command and status codes, and the stack dimensions.
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int DEPTH  = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WORD_W = 32;

  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_LIST = 3'd1;
  localparam logic [2:0] CMD_PEEK = 3'd2;
  localparam logic [2:0] CMD_POP  = 3'd3;
  localparam logic [2:0] CMD_SWAP = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_PEEK_EMPTY = 3'd1;
  localparam logic [2:0] ST_POP_EMPTY  = 3'd2;
  localparam logic [2:0] ST_SWAP_SHORT = 3'd3;
  localparam logic [2:0] ST_PUSH_FULL  = 3'd4;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] out_value;
    logic                     has_value;
    logic [2:0]               status;
    logic                     last;
  } out_item_t;

endpackage

/* hw/rtl/lifo_stack_engine_top.sv */
// ----------------------------------------------------------------------------
// lifo_stack_engine_top
// Bounded LIFO stack of signed 32-bit words with push, pop, peek, swap and
// list commands, one command per input transfer.
//
//   Channel  Ports                          Payload
//   input    in_valid, in_stall, in_data    lse_pkg::in_item_t
//   output   out_valid, out_stall, out_data lse_pkg::out_item_t
//
// Push, pop and failing commands pass through S_EMIT; peek reads the top entry and
// answers from S_PEEK; swap runs S_SW1 to S_SW3, then S_EMIT. List reads the top entry
// and then gives one result per cycle while the output is not stalled, DEPTH at most.
// Reset clears the entry count; the stack memory itself is not cleared.
// A stall on the output holds the result register; one more command is taken
// meanwhile, and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module lifo_stack_engine_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lse_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lse_pkg::out_item_t out_data
);
  import lse_pkg::*;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  lse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lse_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* hw/rtl/lse_ram.sv */
// ----------------------------------------------------------------------------
// lse_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// The read data holds its value until the next read is enabled.
// ----------------------------------------------------------------------------
module lse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/lse_ctrl.sv */
// ----------------------------------------------------------------------------
// lse_ctrl
// Command sequencer of the LIFO stack engine. It holds the entry count,
// drives the stack memory at most one access per cycle and loads the output register.
// ----------------------------------------------------------------------------
module lse_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lse_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lse_pkg::out_item_t          out_data,
  output logic                        ram_we,
  output logic [lse_pkg::ADDR_W-1:0]  ram_waddr,
  output logic [lse_pkg::WORD_W-1:0]  ram_wdata,
  output logic                        ram_re,
  output logic [lse_pkg::ADDR_W-1:0]  ram_raddr,
  input  logic [lse_pkg::WORD_W-1:0]  ram_rdata
);
  import lse_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EMIT = 7'b0000010,
    S_PEEK = 7'b0000100,
    S_SW1  = 7'b0001000,
    S_SW2  = 7'b0010000,
    S_SW3  = 7'b0100000,
    S_LIST = 7'b1000000
  } state_t;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [WORD_W-1:0]   tmp_r, tmp_nxt;
  out_item_t           res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic                out_free;
  logic                in_xfer;
  logic [CNT_W-1:0]    cnt_m1, cnt_m2;
  out_item_t           done_item;

  assign cnt_m1   = count_r - CNT_W'(1);
  assign cnt_m2   = count_r - TWO_C;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    done_item           = '0;
    done_item.status    = ST_OK;
    done_item.last      = 1'b1;
    state_nxt           = state_r;
    count_nxt           = count_r;
    idx_nxt             = idx_r;
    tmp_nxt             = tmp_r;
    res_nxt             = res_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_data_nxt        = out_data_r;
    ram_we              = 1'b0;
    ram_waddr           = '0;
    ram_wdata           = '0;
    ram_re              = 1'b0;
    ram_raddr           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_nxt   = done_item;
          state_nxt = S_EMIT;
          case (in_data.cmd)
            CMD_PUSH: begin
              if (count_r >= DEPTH_C) begin
                res_nxt.status = ST_PUSH_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[ADDR_W-1:0];
                ram_wdata = in_data.push_value;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                res_nxt.status = ST_POP_EMPTY;
              end else begin
                count_nxt = cnt_m1;
              end
            end
            CMD_PEEK: begin
              if (count_r == '0) begin
                res_nxt.status = ST_PEEK_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m1[ADDR_W-1:0];
                state_nxt = S_PEEK;
              end
            end
            CMD_SWAP: begin
              if (count_r < TWO_C) begin
                res_nxt.status = ST_SWAP_SHORT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m1[ADDR_W-1:0];
                state_nxt = S_SW1;
              end
            end
            CMD_LIST: begin
              if (count_r != '0) begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m1[ADDR_W-1:0];
                idx_nxt   = cnt_m1[ADDR_W-1:0];
                state_nxt = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      S_PEEK: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt           = done_item;
          out_data_nxt.out_value = ram_rdata;
          out_data_nxt.has_value = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      S_SW1: begin
        tmp_nxt   = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = cnt_m2[ADDR_W-1:0];
        state_nxt = S_SW2;
      end
      S_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m1[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        state_nxt = S_SW3;
      end
      S_SW3: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m2[ADDR_W-1:0];
        ram_wdata = tmp_r;
        state_nxt = S_EMIT;
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt           = done_item;
          out_data_nxt.out_value = ram_rdata;
          out_data_nxt.has_value = 1'b1;
          out_data_nxt.last      = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r - ADDR_W'(1);
            idx_nxt   = idx_r - ADDR_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    tmp_r      <= tmp_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("Entry count exceeds the stack depth.");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("Stack memory read and write in the same cycle.");

  a_list_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (CNT_W'(idx_r) < count_r))
    else $error("List index is outside the held entries.");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.cmd == CMD_PUSH && count_r < DEPTH_C)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("Push transfer did not raise the entry count.");

  a_more_has_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last) |-> out_data_r.has_value)
    else $error("A non-final result carries no stack entry.");

endmodule

/* tb/sv/lifo_stack_checker.sv */
// ----------------------------------------------------------------------------
// lifo_stack_checker
// Watches both channels of the LIFO stack engine. Every accepted command is
// run through a local stack predictor, and every accepted result is compared
// field by field with the oldest predicted result. The failure count and the
// number of results still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module lifo_stack_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  lse_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  lse_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 items_seen,
  output int                 results_seen,
  output int                 rejects_seen
);
  import lse_pkg::*;

  logic signed [WORD_W-1:0] stack_words [DEPTH];
  int                       stack_depth;
  out_item_t                owed_results [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    items_seen   = 0;
    results_seen = 0;
    rejects_seen = 0;
    stack_depth  = 0;
  end

  function automatic out_item_t make_result(logic signed [WORD_W-1:0] value,
                                            logic has, logic [2:0] status,
                                            logic fin);
    out_item_t r;
    r.out_value = value;
    r.has_value = has;
    r.status    = status;
    r.last      = fin;
    return r;
  endfunction

  function automatic void predict_stack(in_item_t cmd_item);
    logic signed [WORD_W-1:0] top_word;
    case (cmd_item.cmd)
      CMD_PUSH: begin
        if (stack_depth >= DEPTH) begin
          owed_results.push_back(make_result('0, 1'b0, ST_PUSH_FULL, 1'b1));
        end else begin
          stack_words[stack_depth] = cmd_item.push_value;
          stack_depth++;
          owed_results.push_back(make_result('0, 1'b0, ST_OK, 1'b1));
        end
      end
      CMD_LIST: begin
        if (stack_depth == 0) begin
          owed_results.push_back(make_result('0, 1'b0, ST_OK, 1'b1));
        end else begin
          for (int i = stack_depth - 1; i >= 0; i--) begin
            owed_results.push_back(make_result(stack_words[i], 1'b1, ST_OK, i == 0));
          end
        end
      end
      CMD_PEEK: begin
        if (stack_depth == 0) begin
          owed_results.push_back(make_result('0, 1'b0, ST_PEEK_EMPTY, 1'b1));
        end else begin
          owed_results.push_back(make_result(stack_words[stack_depth-1], 1'b1, ST_OK,
                                             1'b1));
        end
      end
      CMD_POP: begin
        if (stack_depth == 0) begin
          owed_results.push_back(make_result('0, 1'b0, ST_POP_EMPTY, 1'b1));
        end else begin
          stack_depth--;
          owed_results.push_back(make_result('0, 1'b0, ST_OK, 1'b1));
        end
      end
      CMD_SWAP: begin
        if (stack_depth < 2) begin
          owed_results.push_back(make_result('0, 1'b0, ST_SWAP_SHORT, 1'b1));
        end else begin
          top_word                   = stack_words[stack_depth-1];
          stack_words[stack_depth-1] = stack_words[stack_depth-2];
          stack_words[stack_depth-2] = top_word;
          owed_results.push_back(make_result('0, 1'b0, ST_OK, 1'b1));
        end
      end
      default: begin
        owed_results.push_back(make_result('0, 1'b0, ST_OK, 1'b1));
      end
    endcase
    if (owed_results[$].status != ST_OK) rejects_seen++;
  endfunction

  task automatic report_mismatch(string field, logic [WORD_W-1:0] want,
                                 logic [WORD_W-1:0] got);
    $display("mismatch at result %0d: %s expected %h, got %h",
             results_seen, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      stack_depth = 0;
      owed_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result, out_value", '0, out_data.out_value);
        end else begin
          want = owed_results.pop_front();
          if (out_data.out_value !== want.out_value)
            report_mismatch("out_value", want.out_value, out_data.out_value);
          if (out_data.has_value !== want.has_value)
            report_mismatch("has_value", WORD_W'(want.has_value),
                            WORD_W'(out_data.has_value));
          if (out_data.status !== want.status)
            report_mismatch("status", WORD_W'(want.status), WORD_W'(out_data.status));
          if (out_data.last !== want.last)
            report_mismatch("last", WORD_W'(want.last), WORD_W'(out_data.last));
        end
      end
      if (in_valid && !in_stall) begin
        items_seen++;
        predict_stack(in_data);
      end
    end
    pending = owed_results.size();
  end

endmodule

/* tb/sv/tb_lifo_stack_engine_top.sv */
// ----------------------------------------------------------------------------
// tb_lifo_stack_engine_top
// Drives the LIFO stack engine with a directed set of commands on empty, one
// entry and mixed stacks, then with random segments of mixed commands, fill
// runs past full and drain runs past empty. Both sides idle at random, and
// once the receiver holds off long enough for the block to stall its input.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lifo_stack_engine_top;
  import lse_pkg::*;

  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 480;
  localparam int LONG_HOLD    = 400;
  localparam int LIMIT_CYCLES = 2_000_000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  bit no_idle       = 1'b0;
  bit long_hold_req = 1'b0;
  int sent_count    = 0;

  int fail_count;
  int pending;
  int items_seen;
  int results_seen;
  int rejects_seen;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lifo_stack_engine_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lifo_stack_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .items_seen   (items_seen),
    .results_seen (results_seen),
    .rejects_seen (rejects_seen)
  );

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 38) return CMD_PUSH;
    if (roll < 63) return CMD_POP;
    if (roll < 73) return CMD_PEEK;
    if (roll < 83) return CMD_SWAP;
    if (roll < 93) return CMD_LIST;
    case ($urandom_range(0, 2))
      0:       return CMD_SPARE_5;
      1:       return CMD_SPARE_6;
      default: return CMD_SPARE_7;
    endcase
  endfunction

  task automatic send_cmd(logic [2:0] cmd, logic signed [WORD_W-1:0] value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.cmd        = cmd;
    in_data.push_value = value;
    in_valid           = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic fill_run();
    int extra;
    extra = $urandom_range(1, 3);
    repeat (DEPTH + extra) send_cmd(CMD_PUSH, pick_value());
    send_cmd(CMD_LIST, pick_value());
  endtask

  initial begin : receiver
    int hold;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = draw_gap();
      end
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int seg_kind;
    int seg_len;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Empty stack, one entry, extremes, then back down past empty.
    send_cmd(CMD_PEEK, '0);
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_SWAP, '0);
    send_cmd(CMD_LIST, '0);
    send_cmd(CMD_PUSH, 32'sh7fffffff);
    send_cmd(CMD_SWAP, '0);
    send_cmd(CMD_PEEK, '1);
    send_cmd(CMD_PUSH, 32'sh80000000);
    send_cmd(CMD_PUSH, '0);
    send_cmd(CMD_PUSH, '1);
    send_cmd(CMD_LIST, '0);
    send_cmd(CMD_SWAP, '0);
    send_cmd(CMD_PEEK, '0);
    send_cmd(CMD_LIST, '0);
    send_cmd(CMD_SPARE_5, '1);
    send_cmd(CMD_SPARE_6, 32'sh55555555);
    send_cmd(CMD_SPARE_7, 32'shaaaaaaaa);
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_PEEK, '0);
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_POP, '0);

    // The receiver holds off while a full stack and its listings pile up.
    no_idle       = 1'b1;
    long_hold_req = 1'b1;
    fill_run();
    send_cmd(CMD_LIST, '0);
    send_cmd(CMD_LIST, '0);

    while (sent_count < RANDOM_ITEMS) begin
      no_idle  = ($urandom_range(0, 3) == 0);
      seg_kind = $urandom_range(0, 9);
      if (seg_kind < 6) begin
        seg_len = $urandom_range(8, 24);
        repeat (seg_len) send_cmd(pick_cmd(), pick_value());
      end else if (seg_kind < 8) begin
        fill_run();
      end else begin
        seg_len = DEPTH + $urandom_range(1, 3);
        repeat (seg_len) send_cmd(CMD_POP, pick_value());
      end
    end
    in_valid = 1'b0;

    wait (pending == 0);
    repeat (DEPTH + 20) @(posedge clk);

    $display("Run covered %0d commands and %0d results, %0d of them rejected",
             items_seen, results_seen, rejects_seen);
    $display("for a full, empty or short stack.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
